// ===== hw/rtl/fba_pkg.sv =====
// Shared constants, types and helpers for the frame bitmap allocator.
package fba_pkg;

    localparam int MAX_FRAMES   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int FRAME_W      = 12;
    localparam int COUNT_W      = 13;
    // word count 0..BITMAP_WORDS inclusive
    localparam int WCOUNT_W     = WORD_IDX_W + 1;

    localparam logic [COUNT_W-1:0]   FRAME_COUNT_RESET = COUNT_W'(MAX_FRAMES);
    localparam logic [WORD_BITS-1:0] FULL_WORD         = '1;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
    typedef logic [FRAME_W-1:0]    frame_t;

    // Request operation codes
    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0]
    {
        STATUS_ALLOCATED = 2'd0,
        STATUS_NOTHING   = 2'd1,
        STATUS_NO_FRAMES = 2'd2,
        STATUS_FREED     = 2'd3
    } status_t;

    // Position of the lowest clear bit; only meaningful when word is not full
    function automatic bit_idx_t lowest_zero(input word_t word);
        bit_idx_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: first-fit page frame allocation over a bitmap memory.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request transaction:
//   operation (0 allocate, 1 free), current_frame, kernel_page, writable_page.
//   Output channel (out_valid / out_stall) returns one result transaction per
//   request: status, frame_number and the present, write and user bits.
//   cfg_we / cfg_wdata write frame_count; write it only while the block is idle.
// Operation:
//   Allocate with current_frame == 0 scans the bitmap memory one word per
//   cycle through its single read port, searching up to 128 words, and
//   stops at the first word that holds a free bit. Free reads the word,
//   clears the frame's bit and writes the word back. Requests that do nothing
//   go straight to the result stage. One request is processed at a time.
// Reset:
//   All frames read as free at once: a per-word valid bit marks words never
//   written, which read as zero. frame_count returns to 4096.
// Stall:
//   A finished result waits in the output register while out_stall is high;
//   the next request is still taken and processed, then held until the
//   output register frees up.
module frame_bitmap_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [fba_pkg::FRAME_W-1:0]   current_frame,
    input  logic                          kernel_page,
    input  logic                          writable_page,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [fba_pkg::FRAME_W-1:0]   frame_number,
    output logic                          present_bit,
    output logic                          write_bit,
    output logic                          user_bit,

    input  logic                          cfg_we,
    input  logic [fba_pkg::COUNT_W-1:0]   cfg_wdata
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WRITE,
        ST_WAIT_OUT
    } state_t;

    state_t                            state_reg;
    logic [fba_pkg::COUNT_W-1:0]       frame_count_reg;

    // Bitmap storage and per-word valid bits
    fba_pkg::word_t                    bitmap_mem [fba_pkg::BITMAP_WORDS];
    logic [fba_pkg::BITMAP_WORDS-1:0]  row_valid_reg;
    fba_pkg::word_t                    rd_data_reg;
    logic                              rd_valid_reg;

    // Scan bookkeeping
    logic [fba_pkg::WCOUNT_W-1:0]      words_reg;
    logic [fba_pkg::WCOUNT_W-1:0]      issue_idx_reg;
    logic                              pend_reg;
    fba_pkg::word_idx_t                pend_idx_reg;
    fba_pkg::bit_idx_t                 free_bit_reg;
    logic                              kern_reg;
    logic                              wr_reg;

    // Staged result
    fba_pkg::status_t                  res_status_reg;
    fba_pkg::frame_t                   res_frame_reg;
    logic                              res_present_reg;
    logic                              res_write_reg;
    logic                              res_user_reg;

    // Output register
    logic                              out_valid_reg;
    logic [1:0]                        status_reg;
    fba_pkg::frame_t                   frame_number_reg;
    logic                              present_reg;
    logic                              write_reg;
    logic                              user_reg;

    logic                              in_accept;
    logic                              out_free;
    logic [fba_pkg::WCOUNT_W-1:0]      words_next;
    fba_pkg::word_t                    cur_word;
    logic                              scan_hit;
    fba_pkg::bit_idx_t                 hit_bit;
    logic                              rd_en;
    fba_pkg::word_idx_t                rd_addr;
    logic                              wr_en;
    fba_pkg::word_idx_t                wr_addr;
    fba_pkg::word_t                    wr_data;

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_number = frame_number_reg;
    assign present_bit  = present_reg;
    assign write_bit    = write_reg;
    assign user_bit     = user_reg;

    // Searched word count, saturated to the bitmap depth
    always_comb
    begin
        if (frame_count_reg[fba_pkg::COUNT_W-1:fba_pkg::BIT_IDX_W] >
            (fba_pkg::COUNT_W-fba_pkg::BIT_IDX_W)'(fba_pkg::BITMAP_WORDS))
        begin
            words_next = fba_pkg::WCOUNT_W'(fba_pkg::BITMAP_WORDS);
        end
        else
        begin
            words_next = fba_pkg::WCOUNT_W'(
                frame_count_reg[fba_pkg::COUNT_W-1:fba_pkg::BIT_IDX_W]);
        end
    end

    // Word returned by the memory; never-written words read as all free
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;
    assign hit_bit  = fba_pkg::lowest_zero(cur_word);
    assign scan_hit = pend_reg && (cur_word != fba_pkg::FULL_WORD);

    // Memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = current_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg;
        wr_data = cur_word;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en = in_accept && (operation == fba_pkg::OP_FREE);
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_word | (fba_pkg::WORD_BITS'(1) << hit_bit);
                end
                else
                begin
                    rd_en   = (issue_idx_reg < words_reg);
                    rd_addr = issue_idx_reg[fba_pkg::WORD_IDX_W-1:0];
                end
            end
            ST_FREE_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = cur_word & ~(fba_pkg::WORD_BITS'(1) << free_bit_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Bitmap memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // Word valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Control state machine and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            issue_idx_reg   <= '0;
            words_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_count_reg <= cfg_wdata;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        kern_reg        <= kernel_page;
                        wr_reg          <= writable_page;
                        res_frame_reg   <= current_frame;
                        res_present_reg <= 1'b0;
                        res_write_reg   <= 1'b0;
                        res_user_reg    <= 1'b0;
                        free_bit_reg    <=
                            current_frame[fba_pkg::BIT_IDX_W-1:0];
                        // word of the freed frame, written back later
                        pend_idx_reg    <=
                            current_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
                        if (current_frame != '0 && operation == fba_pkg::OP_FREE)
                        begin
                            state_reg <= ST_FREE_WRITE;
                        end
                        else if (current_frame == '0 &&
                                 operation == fba_pkg::OP_ALLOC)
                        begin
                            words_reg     <= words_next;
                            issue_idx_reg <= '0;
                            pend_reg      <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                        else
                        begin
                            // page already mapped, or free of frame zero
                            res_status_reg <= fba_pkg::STATUS_NOTHING;
                            state_reg      <= ST_WAIT_OUT;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (scan_hit)
                    begin
                        res_status_reg  <= fba_pkg::STATUS_ALLOCATED;
                        res_frame_reg   <= {pend_idx_reg, hit_bit};
                        res_present_reg <= 1'b1;
                        res_write_reg   <= wr_reg;
                        res_user_reg    <= !kern_reg;
                        pend_reg        <= 1'b0;
                        state_reg       <= ST_WAIT_OUT;
                    end
                    else if (!pend_reg && issue_idx_reg == words_reg)
                    begin
                        // every searched word is full
                        res_status_reg <= fba_pkg::STATUS_NO_FRAMES;
                        state_reg      <= ST_WAIT_OUT;
                    end
                    else if (issue_idx_reg < words_reg)
                    begin
                        pend_reg      <= 1'b1;
                        pend_idx_reg  <= issue_idx_reg[fba_pkg::WORD_IDX_W-1:0];
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end

                ST_FREE_WRITE:
                begin
                    res_status_reg <= fba_pkg::STATUS_FREED;
                    res_frame_reg  <= '0;
                    state_reg      <= ST_WAIT_OUT;
                end

                ST_WAIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= res_status_reg;
                        frame_number_reg <= res_frame_reg;
                        present_reg      <= res_present_reg;
                        write_reg        <= res_write_reg;
                        user_reg         <= res_user_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
